FILE: rtl/ukt_pkg.sv
// Shared types and constants for the unique key table.
package ukt_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int NAME_BYTES_DEF = 8;
	localparam int CAP_W          = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_UPDATE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_DUP     = 3'd2,
		STAT_MISSING = 3'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic  load_req;
		logic  scan_start;
		logic  shift_start;
		logic  run;
		logic  shift;
		logic  wr_add;
		logic  wr_upd;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  out_load;
		logic  out_found;
		stat_t out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic done;
		logic hit;
		logic nhit;
		logic out_busy;
	} dp_sts_t;

endpackage

FILE: rtl/unique_key_table.sv
// Top level of the unique key table with its register port.
// The scan reads one memory entry per cycle for each request; a delete that finds its key then
// shifts the later entries down one place, and an add to a full table answers without a scan.
// One request is in flight at a time, the next is accepted in the cycle after the response is loaded,
// and a response that is not taken holds the controller.
// Reset clears the entry count and sets capacity to 64; the memories are not cleared.
module unique_key_table
	import ukt_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF,
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [1:0]    req_type,
	input  logic [31:0]   key,
	input  logic [31:0]   new_key,
	input  logic [63:0]   value,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output logic [2:0]    status,
	output logic [63:0]   found_value,
	output logic [CW-1:0] entry_count
);

	localparam logic CAP_WORD = 1'b0;

	logic [CAP_W-1:0] cap_q;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == CAP_WORD) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == CAP_WORD) ? 32'(cap_q) : 32'd0;

	ukt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	ukt_dp #(
		.DEPTH     (DEPTH),
		.NAME_BYTES(NAME_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cap        (cap_q),
		.key        (key),
		.new_key    (new_key),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.found_value(found_value),
		.entry_count(entry_count)
	);

endmodule

FILE: rtl/ukt_ctrl.sv
// Controller state machine that sequences the scan, shift and write of each request.
module ukt_ctrl
	import ukt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] req_type,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	req_t   req_q;
	stat_t  stat_q, stat_d;
	logic   stat_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= REQ_ADD;
			stat_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			if (cmd.load_req) begin
				req_q <= req_t'(req_type);
			end
			if (stat_set) begin
				stat_q <= stat_d;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		stat_set  = 1'b0;
		stat_d    = STAT_OK;
		cmd.out_status = stat_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					if (req_t'(req_type) == REQ_ADD && sts.full) begin
						stat_set = 1'b1;
						stat_d   = STAT_FULL;
						state_d  = S_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.run = 1'b1;
				if (sts.done) begin
					stat_set = 1'b1;
					state_d  = S_FINISH;
					unique case (req_q)
						REQ_ADD: begin
							if (sts.hit) begin
								stat_d = STAT_DUP;
							end else begin
								cmd.wr_add  = 1'b1;
								cmd.cnt_inc = 1'b1;
							end
						end
						REQ_DELETE: begin
							if (!sts.hit) begin
								stat_d = STAT_MISSING;
							end else begin
								cmd.shift_start = 1'b1;
								state_d         = S_SHIFT;
							end
						end
						REQ_GET: begin
							if (!sts.hit) begin
								stat_d = STAT_MISSING;
							end
						end
						REQ_UPDATE: begin
							if (!sts.hit) begin
								stat_d = STAT_MISSING;
							end else if (sts.nhit) begin
								stat_d = STAT_DUP;
							end else begin
								cmd.wr_upd = 1'b1;
							end
						end
						default: stat_d = STAT_OK;
					endcase
				end
			end
			S_SHIFT: begin
				cmd.run   = 1'b1;
				cmd.shift = 1'b1;
				if (sts.done) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_load  = 1'b1;
					cmd.out_found = (req_q == REQ_GET) && (stat_q == STAT_OK);
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: rtl/ukt_dp.sv
// Datapath with the key and payload memories, the scan pipeline and the response register.
module ukt_dp
	import ukt_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF,
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic [CAP_W-1:0]  cap,
	input  logic [31:0]       key,
	input  logic [31:0]       new_key,
	input  logic [63:0]       value,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [2:0]        status,
	output logic [63:0]       found_value,
	output logic [CW-1:0]     entry_count
);

	localparam int IW    = $clog2(DEPTH);
	localparam int VW    = 8 * NAME_BYTES;
	localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

	logic [31:0]   key_mem [DEPTH];
	logic [VW-1:0] val_mem [DEPTH];

	logic [31:0]   key_q, nkey_q;
	logic [VW-1:0] val_q;
	logic [CW-1:0] cnt_q, idx_q, slot_q;
	logic          hit_q, nhit_q;
	logic [VW-1:0] found_q;

	logic          rd_v_s1;
	logic [CW-1:0] rd_idx_s1;
	logic [31:0]   rk_s1;
	logic [VW-1:0] rv_s1;

	logic          out_valid_q;
	stat_t         out_status_q;
	logic [63:0]   out_found_q;
	logic [CW-1:0] out_cnt_q;

	logic          issue;
	logic          we;
	logic [IW-1:0] waddr;
	logic [31:0]   wkey;
	logic [VW-1:0] wval;

	assign issue = cmd.run && (idx_q < cnt_q);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wkey  = key_q;
		wval  = val_q;
		if (cmd.shift && rd_v_s1) begin
			we    = 1'b1;
			waddr = IW'(rd_idx_s1 - CW'(1));
			wkey  = rk_s1;
			wval  = rv_s1;
		end else if (cmd.wr_add) begin
			we    = 1'b1;
			waddr = cnt_q[IW-1:0];
		end else if (cmd.wr_upd) begin
			we    = 1'b1;
			waddr = slot_q[IW-1:0];
			wkey  = nkey_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
		rk_s1 <= key_mem[idx_q[IW-1:0]];
		rv_s1 <= val_mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q  <= key;
			nkey_q <= new_key;
			val_q  <= value[VW-1:0];
		end
		rd_idx_s1 <= idx_q;
		if (!cmd.shift && rd_v_s1 && rk_s1 == key_q && !hit_q) begin
			slot_q  <= rd_idx_s1;
			found_q <= rv_s1;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_found_q  <= cmd.out_found ? 64'(found_q) : 64'd0;
			out_cnt_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			nhit_q      <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd.scan_start) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				nhit_q <= 1'b0;
			end else if (cmd.shift_start) begin
				idx_q <= CW'(slot_q + CW'(1));
			end else if (issue) begin
				idx_q <= CW'(idx_q + CW'(1));
			end
			if (!cmd.shift && rd_v_s1) begin
				if (rk_s1 == key_q) begin
					hit_q <= 1'b1;
				end
				if (rk_s1 == nkey_q) begin
					nhit_q <= 1'b1;
				end
			end
			if (cmd.cnt_inc) begin
				cnt_q <= CW'(cnt_q + CW'(1));
			end else if (cmd.cnt_dec) begin
				cnt_q <= CW'(cnt_q - CW'(1));
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.full = (CMP_W'(cnt_q) >= CMP_W'(cap)) || (CMP_W'(cnt_q) >= CMP_W'(DEPTH));
		sts.done = (idx_q >= cnt_q) && !rd_v_s1;
		sts.hit  = hit_q;
		sts.nhit = nhit_q;
		sts.out_busy = out_valid_q && !rsp_ready;
	end

	assign rsp_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found_value = out_found_q;
	assign entry_count = out_cnt_q;

endmodule
